@@ src/tmpg_pkg.sv @@
// ----------------------------------------------------------------------------
// tmpg_pkg
// Shared constants, types and the color palette of the text mode pixel
// generator: frame geometry, memory map of the character stores, request codes.
// ----------------------------------------------------------------------------
package tmpg_pkg;

    // text screen geometry
    localparam int TEXT_COLUMNS = 40;
    localparam int TEXT_ROWS    = 25;
    localparam int BORDER_WIDTH = 32;

    localparam int FRAME_W    = 8 * TEXT_COLUMNS + 2 * BORDER_WIDTH;
    localparam int FRAME_H    = 8 * TEXT_ROWS + 2 * BORDER_WIDTH;
    localparam int CELL_COUNT = TEXT_COLUMNS * TEXT_ROWS;

    // raster counter and store index widths
    localparam int X_W    = $clog2(FRAME_W + 1);
    localparam int Y_W    = $clog2(FRAME_H + 1);
    localparam int CELL_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    localparam int GLYPH_DEPTH = 2048;
    localparam int GLYPH_AW    = 11;

    // port widths
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int PIX_W   = 9;
    localparam int COLOR_W = 8;

    // memory map
    localparam logic [ADDR_W-1:0] CODE_BASE   = 16'h0400;
    localparam logic [ADDR_W-1:0] COLOR_BASE  = 16'hD800;
    localparam logic [ADDR_W-1:0] GLYPH_BASE  = 16'hD000;
    localparam logic [ADDR_W-1:0] BORDER_ADDR = 16'hD020;
    localparam logic [ADDR_W-1:0] BACK_ADDR   = 16'hD021;
    localparam logic [DATA_W-1:0] NIBBLE_MASK = 8'h0F;

    // request codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // configuration register indexes
    localparam logic REG_COLOR_MASK = 1'b0;
    localparam logic REG_SYNC_BITS  = 1'b1;

    localparam logic [COLOR_W-1:0] COLOR_MASK_RESET = 8'd63;
    localparam logic [COLOR_W-1:0] SYNC_BITS_RESET  = 8'd0;

    // current raster position and its place in the text area
    typedef struct packed {
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic              last;
        logic              in_text;
        logic [2:0]        bitsel;
        logic [2:0]        line;
        logic [CELL_W-1:0] cell_idx;
    } pix_info_t;

    // store write request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } mem_wr_t;

    // fixed 16-entry palette
    function automatic logic [COLOR_W-1:0] palette_base(input logic [3:0] idx);
        logic [COLOR_W-1:0] c;
        case (idx)
            4'd0:    c = 8'h00;
            4'd1:    c = 8'h3F;
            4'd2:    c = 8'h01;
            4'd3:    c = 8'h29;
            4'd4:    c = 8'h21;
            4'd5:    c = 8'h19;
            4'd6:    c = 8'h10;
            4'd7:    c = 8'h1E;
            4'd8:    c = 8'h05;
            4'd9:    c = 8'h01;
            4'd10:   c = 8'h16;
            4'd11:   c = 8'h15;
            4'd12:   c = 8'h15;
            4'd13:   c = 8'h2E;
            4'd14:   c = 8'h25;
            4'd15:   c = 8'h2A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ src/tmpg_raster.sv @@
// ----------------------------------------------------------------------------
// tmpg_raster
// Raster position counter. Gives the current pixel's frame coordinates, the
// text cell under it and the glyph bit and line, and steps on each tick.
// ----------------------------------------------------------------------------
module tmpg_raster
    import tmpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    output pix_info_t info
);

    logic [X_W-1:0] col_reg;
    logic [X_W-1:0] col_next;
    logic [Y_W-1:0] row_reg;
    logic [Y_W-1:0] row_next;
    logic [X_W-1:0] tx;
    logic [Y_W-1:0] ty;
    logic           col_end;
    logic           row_end;

    // position relative to the text area
    assign tx      = col_reg - X_W'(BORDER_WIDTH);
    assign ty      = row_reg - Y_W'(BORDER_WIDTH);
    assign col_end = (col_reg == X_W'(FRAME_W - 1));
    assign row_end = (row_reg == Y_W'(FRAME_H - 1));

    // pixel description
    always_comb
    begin
        info.x        = col_reg;
        info.y        = row_reg;
        info.last     = col_end && row_end;
        info.in_text  = (col_reg >= X_W'(BORDER_WIDTH)) && (row_reg >= Y_W'(BORDER_WIDTH))
                        && (tx < X_W'(8 * TEXT_COLUMNS)) && (ty < Y_W'(8 * TEXT_ROWS));
        info.bitsel   = tx[2:0];
        info.line     = ty[2:0];
        info.cell_idx = CELL_W'(CELL_W'(ty[Y_W-1:3]) * CELL_W'(TEXT_COLUMNS)
                                + CELL_W'(tx[X_W-1:3]));
    end

    // raster step with wrap
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

@@ src/tmpg_vram.sv @@
// ----------------------------------------------------------------------------
// tmpg_vram
// Character stores: screen codes, color nibbles and glyph patterns. Decodes
// write requests by address and gives registered reads.
// ----------------------------------------------------------------------------
module tmpg_vram
    import tmpg_pkg::*;
(
    input  logic                clk,
    input  mem_wr_t             wr,
    input  logic                cell_rd_en,
    input  logic [CELL_W-1:0]   cell_addr,
    input  logic                glyph_rd_en,
    input  logic [GLYPH_AW-1:0] glyph_addr,
    output logic [DATA_W-1:0]   screen_rd,
    output logic [3:0]          color_rd,
    output logic [DATA_W-1:0]   glyph_rd
);

    logic [DATA_W-1:0] screen_mem [CELL_COUNT];
    logic [3:0]        color_mem  [CELL_COUNT];
    logic [DATA_W-1:0] glyph_mem  [GLYPH_DEPTH];

    logic [DATA_W-1:0] screen_rd_reg;
    logic [3:0]        color_rd_reg;
    logic [DATA_W-1:0] glyph_rd_reg;

    logic [ADDR_W-1:0] scr_off;
    logic [ADDR_W-1:0] col_off;
    logic [ADDR_W-1:0] gly_off;
    logic              scr_hit;
    logic              col_hit;
    logic              gly_hit;

    // address decode
    assign scr_off = wr.addr - CODE_BASE;
    assign col_off = wr.addr - COLOR_BASE;
    assign gly_off = wr.addr - GLYPH_BASE;
    assign scr_hit = wr.en && (wr.addr >= CODE_BASE) && (scr_off < ADDR_W'(CELL_COUNT));
    assign col_hit = wr.en && (wr.addr >= COLOR_BASE) && (col_off < ADDR_W'(CELL_COUNT));
    assign gly_hit = wr.en && (wr.addr >= GLYPH_BASE) && (gly_off < ADDR_W'(GLYPH_DEPTH));

    // screen code store
    always_ff @(posedge clk)
    begin
        if (scr_hit)
            screen_mem[scr_off[CELL_W-1:0]] <= wr.data;
        if (cell_rd_en)
            screen_rd_reg <= screen_mem[cell_addr];
    end

    // color nibble store
    always_ff @(posedge clk)
    begin
        if (col_hit)
            color_mem[col_off[CELL_W-1:0]] <= wr.data[3:0];
        if (cell_rd_en)
            color_rd_reg <= color_mem[cell_addr];
    end

    // glyph pattern store, read returns the old entry on a same-cycle write
    always_ff @(posedge clk)
    begin
        if (gly_hit)
            glyph_mem[gly_off[GLYPH_AW-1:0]] <= wr.data;
        if (glyph_rd_en)
            glyph_rd_reg <= glyph_mem[glyph_addr];
    end

    assign screen_rd = screen_rd_reg;
    assign color_rd  = color_rd_reg;
    assign glyph_rd  = glyph_rd_reg;

endmodule

@@ src/text_mode_pixel_generator_top.sv @@
// Path: a tick request's pixel passes the cell read, glyph read and output
// registers in that order; write requests give no pixel. Throughput: one
// request per cycle unless out_ready holds the pipeline; each store has a single read port.
// Reset: raster, color indices and pipeline clear at once, registers take their
// reset values; the character stores hold nothing defined until written.
// ----------------------------------------------------------------------------
// text_mode_pixel_generator_top
// Renders a bordered text screen one pixel per tick request, raster order,
// through a three stage elastic pipeline around the character stores.
// ----------------------------------------------------------------------------
module text_mode_pixel_generator_top
    import tmpg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [COLOR_W-1:0] cfg_data,
    // request channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic [ADDR_W-1:0]  write_address,
    input  logic [DATA_W-1:0]  write_data,
    // pixel channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PIX_W-1:0]   pixel_x,
    output logic [PIX_W-1:0]   pixel_y,
    output logic [COLOR_W-1:0] pixel_color,
    output logic               frame_end
);

    logic [COLOR_W-1:0] color_mask_reg;
    logic [COLOR_W-1:0] sync_bits_reg;
    logic [3:0]         border_reg;
    logic [3:0]         back_reg;

    logic      out_en;
    logic      s2_en;
    logic      s1_en;
    logic      tick_acc;
    mem_wr_t   wr;
    pix_info_t info;

    logic      s1_valid_reg;
    pix_info_t s1_reg;
    logic [3:0] s1_border_reg;
    logic [3:0] s1_back_reg;

    logic       s2_valid_reg;
    pix_info_t  s2_reg;
    logic [3:0] s2_border_reg;
    logic [3:0] s2_back_reg;
    logic [3:0] s2_fg_reg;

    logic               out_valid_reg;
    logic [X_W-1:0]     out_x_reg;
    logic [Y_W-1:0]     out_y_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_last_reg;

    logic [DATA_W-1:0]  screen_rd;
    logic [3:0]         color_rd;
    logic [DATA_W-1:0]  glyph_rd;
    logic [3:0]         color_idx;
    logic [COLOR_W-1:0] color_next;

    // stage enables, each stage moves when the next one is free or moving
    assign out_en   = !out_valid_reg || out_ready;
    assign s2_en    = !s2_valid_reg || out_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;
    assign tick_acc = in_valid && in_ready && (op == OP_TICK);

    assign wr.en   = in_valid && in_ready && (op == OP_WRITE);
    assign wr.addr = write_address;
    assign wr.data = write_data;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mask_reg <= COLOR_MASK_RESET;
            sync_bits_reg  <= SYNC_BITS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_COLOR_MASK: color_mask_reg <= cfg_data;
                REG_SYNC_BITS:  sync_bits_reg  <= cfg_data;
                default:        color_mask_reg <= color_mask_reg;
            endcase
        end
    end

    // border and background color indices
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            border_reg <= '0;
            back_reg   <= '0;
        end
        else if (wr.en)
        begin
            if (wr.addr == BORDER_ADDR)
                border_reg <= wr.data[3:0] & NIBBLE_MASK[3:0];
            if (wr.addr == BACK_ADDR)
                back_reg <= wr.data[3:0] & NIBBLE_MASK[3:0];
        end
    end

    tmpg_raster u_raster
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (tick_acc),
        .info    (info)
    );

    tmpg_vram u_vram
    (
        .clk         (clk),
        .wr          (wr),
        .cell_rd_en  (tick_acc && info.in_text),
        .cell_addr   (info.cell_idx),
        .glyph_rd_en (s1_valid_reg && s2_en && s1_reg.in_text),
        .glyph_addr  (GLYPH_AW'({screen_rd, s1_reg.line})),
        .screen_rd   (screen_rd),
        .color_rd    (color_rd),
        .glyph_rd    (glyph_rd)
    );

    // stage 1: raster position, cell read under way
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_en)
            s1_valid_reg <= tick_acc;
    end

    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            s1_reg        <= info;
            s1_border_reg <= border_reg;
            s1_back_reg   <= back_reg;
        end
    end

    // stage 2: glyph read under way, cell color captured
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_en && s1_valid_reg)
        begin
            s2_reg        <= s1_reg;
            s2_border_reg <= s1_border_reg;
            s2_back_reg   <= s1_back_reg;
            s2_fg_reg     <= color_rd;
        end
    end

    // color select and palette
    always_comb
    begin
        if (!s2_reg.in_text)
            color_idx = s2_border_reg;
        else if (glyph_rd[3'd7 - s2_reg.bitsel])
            color_idx = s2_fg_reg;
        else
            color_idx = s2_back_reg;
        color_next = (palette_base(color_idx) & color_mask_reg) | sync_bits_reg;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_en)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_en && s2_valid_reg)
        begin
            out_x_reg     <= s2_reg.x;
            out_y_reg     <= s2_reg.y;
            out_last_reg  <= s2_reg.last;
            out_color_reg <= color_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = PIX_W'(out_x_reg);
    assign pixel_y     = PIX_W'(out_y_reg);
    assign pixel_color = out_color_reg;
    assign frame_end   = out_last_reg;

`ifndef SYNTH
    // the frame end flag sits on the last frame position only
    a_frame_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_last_reg |->
            (out_x_reg == X_W'(FRAME_W - 1)) && (out_y_reg == Y_W'(FRAME_H - 1)))
        else $error("frame end flag off the last pixel");

    // requests are refused only when every stage holds a pixel
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && s2_valid_reg && out_valid_reg)
        else $error("request refused with a free stage");

    // raster column stays inside the frame
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_reg.x < X_W'(FRAME_W)))
        else $error("raster column beyond frame");
`endif

endmodule

@@ bench/text_mode_pixel_generator_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_mode_pixel_generator_top_tb
// Self-checking bench for the text mode pixel generator. It fills the character
// stores, then checks every pixel against a behavioral mirror of the screen.
// The run covers the address map edges, the palette under several mask and
// sync settings, the text area under random store updates, a long output
// stall and a whole frame up to its wrap.
// ----------------------------------------------------------------------------
module text_mode_pixel_generator_top_tb
    import tmpg_pkg::*;
();

    localparam int FRAME_PIXELS = FRAME_W * FRAME_H;
    localparam int PIPE_SETTLE  = 8;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int WATCHDOG_NS  = 100_000_000;
    localparam int HOLD_OFF_LEN = 300;

    // fixed palette, entry n at bits 8n+7:8n
    localparam logic [16*COLOR_W-1:0] PALETTE = {
        8'h2A, 8'h25, 8'h2E, 8'h15, 8'h15, 8'h16, 8'h01, 8'h05,
        8'h1E, 8'h10, 8'h19, 8'h21, 8'h29, 8'h01, 8'h3F, 8'h00
    };

    typedef struct packed {
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pixel_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = REG_COLOR_MASK;
    logic [COLOR_W-1:0] cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               op = OP_WRITE;
    logic [ADDR_W-1:0]  write_address = '0;
    logic [DATA_W-1:0]  write_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               frame_end;

    // mirror of the screen state
    logic [7:0]         screen_mirror [CELL_COUNT];
    logic [3:0]         color_mirror [CELL_COUNT];
    logic [7:0]         glyph_mirror [GLYPH_DEPTH];
    logic [3:0]         border_mirror = 4'd0;
    logic [3:0]         back_mirror = 4'd0;
    int                 raster_x = 0;
    int                 raster_y = 0;
    logic [COLOR_W-1:0] mask_mirror = COLOR_MASK_RESET;
    logic [COLOR_W-1:0] sync_mirror = SYNC_BITS_RESET;

    pixel_t pending_pixels [$];
    int     error_count = 0;
    int     ticks_sent = 0;
    bit     idle_on = 1'b1;
    int     hold_off_cycles = 0;

    text_mode_pixel_generator_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .write_address (write_address),
        .write_data    (write_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_color   (pixel_color),
        .frame_end     (frame_end)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        #(WATCHDOG_NS);
        $display("text_mode_pixel_generator_top_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // screen mirror
    // ------------------------------------------------------------------------

    function automatic logic [COLOR_W-1:0] shade(input logic [3:0] idx);
        return (PALETTE[idx*COLOR_W +: COLOR_W] & mask_mirror) | sync_mirror;
    endfunction

    function automatic logic [COLOR_W-1:0] render_pixel(input int px, input int py);
        int         cell_idx;
        int         code;
        int         line;
        int         bit_pos;
        logic [7:0] pattern;
        if (px < BORDER_WIDTH || py < BORDER_WIDTH ||
            px - BORDER_WIDTH >= 8 * TEXT_COLUMNS || py - BORDER_WIDTH >= 8 * TEXT_ROWS)
            return shade(border_mirror);
        cell_idx = ((py - BORDER_WIDTH) / 8) * TEXT_COLUMNS + (px - BORDER_WIDTH) / 8;
        line     = (py - BORDER_WIDTH) % 8;
        bit_pos  = (px - BORDER_WIDTH) % 8;
        code     = screen_mirror[cell_idx];
        pattern  = glyph_mirror[(code * 8 + line) % GLYPH_DEPTH];
        // leftmost pixel of a cell is the glyph msb
        if (pattern[7 - bit_pos])
            return shade(color_mirror[cell_idx]);
        return shade(back_mirror);
    endfunction

    function automatic void predict_request(input logic req_op,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [DATA_W-1:0] data);
        int unsigned a;
        pixel_t      px;
        a = addr;
        if (req_op == OP_WRITE)
        begin
            if (a >= CODE_BASE && a - CODE_BASE < CELL_COUNT)
                screen_mirror[a - CODE_BASE] = data;
            if (a >= COLOR_BASE && a - COLOR_BASE < CELL_COUNT)
                color_mirror[a - COLOR_BASE] = data[3:0];
            if (a >= GLYPH_BASE && a - GLYPH_BASE < GLYPH_DEPTH)
                glyph_mirror[a - GLYPH_BASE] = data;
            if (addr == BORDER_ADDR)
                border_mirror = data[3:0];
            if (addr == BACK_ADDR)
                back_mirror = data[3:0];
        end
        else
        begin
            px.x     = PIX_W'(raster_x);
            px.y     = PIX_W'(raster_y);
            px.color = render_pixel(raster_x, raster_y);
            px.last  = (raster_x == FRAME_W - 1) && (raster_y == FRAME_H - 1);
            pending_pixels.push_back(px);
            // raster advance with row and frame wrap
            if (raster_x + 1 >= FRAME_W)
            begin
                raster_x = 0;
                raster_y = (raster_y + 1 >= FRAME_H) ? 0 : raster_y + 1;
            end
            else
            begin
                raster_x = raster_x + 1;
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (error_count < 100)
            $display("%0t: mismatch on %s: got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // handshake tracking and pixel checks
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : pixel_check
        pixel_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_COLOR_MASK)
                    mask_mirror = cfg_data;
                else
                    sync_mirror = cfg_data;
            end
            if (in_valid && in_ready)
                predict_request(op, write_address, write_data);
            if (out_valid && out_ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    report_mismatch("pixel with no request", {7'd0, pixel_x}, 16'd0);
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (pixel_x !== want.x)
                        report_mismatch("pixel_x", {7'd0, pixel_x}, {7'd0, want.x});
                    if (pixel_y !== want.y)
                        report_mismatch("pixel_y", {7'd0, pixel_y}, {7'd0, want.y});
                    if (pixel_color !== want.color)
                        report_mismatch("pixel_color", {8'd0, pixel_color},
                                        {8'd0, want.color});
                    if (frame_end !== want.last)
                        report_mismatch("frame_end", {15'd0, frame_end}, {15'd0, want.last});
                end
            end
        end
    end

    // pixel sink: random stall bursts and the long hold-off
    initial
    begin : pixel_sink
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                while (hold_off_cycles > 0)
                begin
                    @(posedge clk);
                    hold_off_cycles--;
                end
                out_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 11) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // request and register drivers
    // ------------------------------------------------------------------------

    task automatic send_req(input logic req_op, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= req_op;
        write_address <= addr;
        write_data    <= data;
        do @(posedge clk); while (!in_ready);
        if (req_op == OP_TICK)
            ticks_sent++;
    endtask

    // tick payload is ignored, so it carries random bits
    task automatic send_tick();
        send_req(OP_TICK, ADDR_W'($urandom), DATA_W'($urandom));
    endtask

    task automatic send_random_write();
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        data = DATA_W'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2: addr = CODE_BASE + ADDR_W'($urandom_range(0, CELL_COUNT - 1));
            3, 4:    addr = COLOR_BASE + ADDR_W'($urandom_range(0, CELL_COUNT - 1));
            5, 6:    addr = GLYPH_BASE + ADDR_W'($urandom_range(0, GLYPH_DEPTH - 1));
            7:       addr = ($urandom_range(0, 1) == 0) ? BORDER_ADDR : BACK_ADDR;
            default: addr = ADDR_W'($urandom);
        endcase
        send_req(OP_WRITE, addr, data);
    endtask

    task automatic write_reg(input logic idx, input logic [COLOR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every pixel, then let trailing writes settle
    task automatic drain();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // every store entry gets written before any pixel can read it
    task automatic test_store_fill();
        for (int k = 0; k < CELL_COUNT; k++)
            send_req(OP_WRITE, CODE_BASE + ADDR_W'(k), DATA_W'($urandom));
        for (int k = 0; k < CELL_COUNT; k++)
            send_req(OP_WRITE, COLOR_BASE + ADDR_W'(k), DATA_W'($urandom));
        for (int k = 0; k < GLYPH_DEPTH; k++)
            send_req(OP_WRITE, GLYPH_BASE + ADDR_W'(k), DATA_W'($urandom));
    endtask

    // edges of the address map under the reset register values
    task automatic test_address_map();
        send_tick();
        send_req(OP_WRITE, 16'h0000, 8'hFF);
        send_req(OP_WRITE, 16'hFFFF, 8'hFF);
        send_req(OP_WRITE, CODE_BASE - 16'd1, 8'hA5);
        send_req(OP_WRITE, CODE_BASE, 8'h00);
        send_req(OP_WRITE, CODE_BASE + ADDR_W'(CELL_COUNT - 1), 8'hFF);
        send_req(OP_WRITE, CODE_BASE + ADDR_W'(CELL_COUNT), 8'h5A);
        send_req(OP_WRITE, GLYPH_BASE - 16'd1, 8'hFF);
        send_req(OP_WRITE, GLYPH_BASE, 8'hFF);
        send_req(OP_WRITE, GLYPH_BASE + ADDR_W'(GLYPH_DEPTH - 1), 8'h00);
        send_req(OP_WRITE, COLOR_BASE, 8'hFF);
        send_req(OP_WRITE, COLOR_BASE + ADDR_W'(CELL_COUNT - 1), 8'h5A);
        send_req(OP_WRITE, COLOR_BASE + ADDR_W'(CELL_COUNT), 8'hFF);
        send_req(OP_WRITE, BORDER_ADDR, 8'hFF);
        send_tick();
        send_req(OP_WRITE, BACK_ADDR, 8'hF0);
        send_req(OP_WRITE, BORDER_ADDR, 8'h00);
        send_tick();
        send_req(OP_TICK, 16'hFFFF, 8'hFF);
        send_req(OP_WRITE, BORDER_ADDR, 8'h31);
        send_tick();
    endtask

    // all 16 palette entries on the border under one register setting
    task automatic sweep_border_colors(input logic [COLOR_W-1:0] mask,
                                       input logic [COLOR_W-1:0] sync);
        drain();
        write_reg(REG_COLOR_MASK, mask);
        write_reg(REG_SYNC_BITS, sync);
        for (int i = 0; i < 16; i++)
        begin
            send_req(OP_WRITE, BORDER_ADDR, {4'($urandom), 4'(i)});
            send_tick();
            send_tick();
        end
    endtask

    task automatic test_palette_config();
        sweep_border_colors(8'hFF, 8'h00);
        sweep_border_colors(8'h00, 8'hFF);
        sweep_border_colors(8'hFF, 8'hFF);
        sweep_border_colors(8'h00, 8'h00);
        sweep_border_colors(COLOR_W'($urandom), COLOR_W'($urandom));
    endtask

    // run down to the text rows with rare writes, then random store updates among the pixels
    task automatic test_text_area_random();
        drain();
        write_reg(REG_COLOR_MASK, 8'hFF);
        write_reg(REG_SYNC_BITS, 8'h00);
        while ((ticks_sent % FRAME_PIXELS) < BORDER_WIDTH * FRAME_W)
        begin
            if ($urandom_range(0, 19) == 0)
                send_random_write();
            else
                send_tick();
        end
        repeat (1200)
        begin
            if ($urandom_range(0, 3) == 0)
                send_random_write();
            else
                send_tick();
        end
    endtask

    // sink holds off long enough for the pipeline to fill and stall requests
    task automatic test_backpressure();
        hold_off_cycles = HOLD_OFF_LEN;
        repeat (64) send_tick();
        drain();
    endtask

    // through the rest of the frame, its last pixel and into the next one
    task automatic test_frame_wrap();
        int remaining;
        drain();
        write_reg(REG_COLOR_MASK, COLOR_W'($urandom));
        write_reg(REG_SYNC_BITS, COLOR_W'($urandom));
        idle_on   = 1'b0;
        remaining = FRAME_PIXELS - (ticks_sent % FRAME_PIXELS) + 2 * FRAME_W;
        while (remaining > 0)
        begin
            if ($urandom_range(0, 31) == 0)
            begin
                send_random_write();
            end
            else
            begin
                send_tick();
                remaining--;
            end
        end
    endtask

    initial
    begin : test_sequence
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_store_fill();
        test_address_map();
        test_palette_config();
        test_text_area_random();
        test_backpressure();
        test_frame_wrap();

        drain();
        if (pending_pixels.size() != 0)
            report_mismatch("pixels never produced", 16'(pending_pixels.size()), 16'd0);
        if (error_count == 0)
            $display("text_mode_pixel_generator_top_tb passed");
        else
            $display("text_mode_pixel_generator_top_tb failed");
        $finish;
    end

endmodule
